/* hdl/cbp_pkg.sv */
package cbp_pkg;

    // fixed payload widths
    localparam int BLOCK_W  = 32;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 2;
    localparam int FIU_W    = 7;

    // frames_in_use reset value
    localparam logic [FIU_W-1:0] FIU_RESET = 7'd64;

    // command codes
    localparam logic CMD_PIN   = 1'b0;
    localparam logic CMD_UNPIN = 1'b1;

    // result status codes
    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_OK           = 2'd0;
    localparam status_t ST_NO_FREE      = 2'd1;
    localparam status_t ST_NOT_RESIDENT = 2'd2;
    localparam status_t ST_UNDERFLOW    = 2'd3;

endpackage

/* hdl/cbp_req_if.sv */
interface cbp_req_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [cbp_pkg::BLOCK_W-1:0] block_num;

    modport source (output valid, output command, output block_num, input ready);
    modport sink   (input valid, input command, input block_num, output ready);
endinterface

/* hdl/cbp_rsp_if.sv */
interface cbp_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [cbp_pkg::INDEX_W-1:0] frame_index;
    logic                        fetch_needed;
    logic                        evicted_valid;
    logic [cbp_pkg::BLOCK_W-1:0] evicted_block;
    cbp_pkg::status_t            status;

    modport source (
        output valid, output hit, output frame_index, output fetch_needed,
        output evicted_valid, output evicted_block, output status,
        input  ready
    );
    modport sink (
        input  valid, input hit, input frame_index, input fetch_needed,
        input  evicted_valid, input evicted_block, input status,
        output ready
    );
endinterface

/* hdl/cbp_frame_mem.sv */
module cbp_frame_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 50
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/cbp_hand_mod.sv */
module cbp_hand_mod #(
    parameter int HW    = 6,
    parameter int CNT_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [HW-1:0]    dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [HW-1:0]    remainder
);

    localparam int DW = CNT_W + HW;
    localparam int KW = (HW > 1) ? $clog2(HW) : 1;

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [KW-1:0] k_reg, k_next;
    logic [HW-1:0] rem_reg, rem_next;
    logic [DW-1:0] shifted;

    // restoring remainder, one quotient bit per cycle
    always_comb
    begin
        shifted   = DW'(divisor) << k_reg;
        run_next  = run_reg;
        k_next    = k_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        if (start)
        begin
            run_next = 1'b1;
            k_next   = KW'(HW - 1);
            rem_next = dividend;
        end
        else if (run_reg)
        begin
            if (DW'(rem_reg) >= shifted)
            begin
                rem_next = rem_reg - shifted[HW-1:0];
            end
            if (k_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                k_next = k_reg - KW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* hdl/clock_buffer_pool_frame_manager_unit.sv */
// a lookup reads the n frames in use in order up to a match, one frame read per cycle
// a miss on a pin then wraps the clock hand (remainder by n) and sweeps up to 2n
// frames, one frame per cycle; the result then passes through ST_OUT to the output registers
// one request at a time: a new one is taken only in the idle state
// reset: asynchronous, active low; a clearing pass then writes all FRAME_COUNT frames
// empty while no request is taken (configuration writes still land)
module clock_buffer_pool_frame_manager_unit #(
    parameter int FRAME_COUNT = 64,
    parameter int BLOCK_BITS  = 32,
    parameter int PIN_BITS    = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    cbp_req_if.sink                   req,
    cbp_rsp_if.source                 rsp,
    input  logic                      cfg_wr_en,
    input  logic [cbp_pkg::FIU_W-1:0] cfg_wr_data
);

    localparam int HW    = $clog2(FRAME_COUNT);
    localparam int CNT_W = $clog2(FRAME_COUNT + 1);
    localparam int EW    = BLOCK_BITS + PIN_BITS + 2;
    localparam int V_BIT = EW - 1;
    localparam int S_BIT = EW - 2;
    localparam int P_LSB = BLOCK_BITS;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LOOK  = 3'd2;
    localparam logic [2:0] ST_MOD   = 3'd3;
    localparam logic [2:0] ST_SWEEP = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic                     cmd_reg, cmd_next;
    logic [BLOCK_BITS-1:0]    blk_reg, blk_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic [HW-1:0]            sw_ptr_reg, sw_ptr_next;
    logic                     pend_reg, pend_next;
    logic [HW-1:0]            pend_addr_reg, pend_addr_next;
    logic [CNT_W:0]           step_reg, step_next;
    logic [HW-1:0]            hand_reg, hand_next;
    logic [HW-1:0]            clr_reg, clr_next;
    logic                     fwd_hit_reg;
    logic [EW-1:0]            fwd_data_reg;
    logic [cbp_pkg::FIU_W-1:0] fiu_reg;

    logic                        res_hit_reg, res_hit_next;
    logic [cbp_pkg::INDEX_W-1:0] res_idx_reg, res_idx_next;
    logic                        res_fetch_reg, res_fetch_next;
    logic                        res_evv_reg, res_evv_next;
    logic [cbp_pkg::BLOCK_W-1:0] res_evb_reg, res_evb_next;
    cbp_pkg::status_t            res_status_reg, res_status_next;

    logic                        rsp_valid_reg;
    logic                        rsp_hit_reg;
    logic [cbp_pkg::INDEX_W-1:0] rsp_idx_reg;
    logic                        rsp_fetch_reg;
    logic                        rsp_evv_reg;
    logic [cbp_pkg::BLOCK_W-1:0] rsp_evb_reg;
    cbp_pkg::status_t            rsp_status_reg;
    logic                        rsp_load;

    logic          mem_we;
    logic [HW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [HW-1:0] mem_raddr;
    logic [EW-1:0] mem_rdata;

    logic          mod_start;
    logic          mod_done;
    logic [HW-1:0] mod_rem;

    logic [EW-1:0]            ent;
    logic                     ent_valid;
    logic                     ent_sc;
    logic [PIN_BITS-1:0]      ent_pins;
    logic [BLOCK_BITS-1:0]    ent_block;
    logic [CNT_W-1:0]         n_calc;
    logic                     sweep_end;

    // advance the clock hand with wrap at the frame count
    function automatic logic [HW-1:0] hand_step(input logic [HW-1:0] p,
                                                input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] p1;
        begin
            p1 = CNT_W'(p) + CNT_W'(1);
            hand_step = (p1 == n) ? '0 : p1[HW-1:0];
        end
    endfunction

    cbp_frame_mem #(
        .DEPTH (FRAME_COUNT),
        .AW    (HW),
        .DW    (EW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    cbp_hand_mod #(
        .HW    (HW),
        .CNT_W (CNT_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (hand_reg),
        .divisor   (n_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // read data with forwarding of a same-address write
    always_comb
    begin
        ent       = fwd_hit_reg ? fwd_data_reg : mem_rdata;
        ent_valid = ent[V_BIT];
        ent_sc    = ent[S_BIT];
        ent_pins  = ent[P_LSB +: PIN_BITS];
        ent_block = ent[BLOCK_BITS-1:0];
    end

    // effective frame count from the register
    always_comb
    begin
        if (fiu_reg == '0)
        begin
            n_calc = CNT_W'(1);
        end
        else if (int'(fiu_reg) > FRAME_COUNT)
        begin
            n_calc = CNT_W'(FRAME_COUNT);
        end
        else
        begin
            n_calc = CNT_W'(fiu_reg);
        end
    end

    assign sweep_end = ((step_reg + (CNT_W+1)'(1)) == {n_reg, 1'b0});
    assign req.ready = (state_reg == ST_IDLE);
    assign rsp_load  = (state_reg == ST_OUT) && (!rsp_valid_reg || rsp.ready);

    // control sequencer
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        blk_next        = blk_reg;
        n_next          = n_reg;
        idx_next        = idx_reg;
        sw_ptr_next     = sw_ptr_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        step_next       = step_reg;
        hand_next       = hand_reg;
        clr_next        = clr_reg;
        res_hit_next    = res_hit_reg;
        res_idx_next    = res_idx_reg;
        res_fetch_next  = res_fetch_reg;
        res_evv_next    = res_evv_reg;
        res_evb_next    = res_evb_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = pend_addr_reg;
        mem_wdata       = ent;
        mem_raddr       = '0;
        mod_start       = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + HW'(1);
                if (clr_reg == HW'(FRAME_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = req.command;
                    blk_next   = BLOCK_BITS'(req.block_num);
                    n_next     = n_calc;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (pend_reg && ent_valid && (ent_block == blk_reg))
                begin
                    // resident: update pins in place
                    res_hit_next    = 1'b1;
                    res_idx_next    = cbp_pkg::INDEX_W'(pend_addr_reg);
                    res_fetch_next  = 1'b0;
                    res_evv_next    = 1'b0;
                    res_evb_next    = '0;
                    res_status_next = cbp_pkg::ST_OK;
                    pend_next       = 1'b0;
                    state_next      = ST_OUT;
                    if (cmd_reg == cbp_pkg::CMD_PIN)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = {1'b1, 1'b1,
                                     (ent_pins == '1) ? ent_pins
                                                      : ent_pins + PIN_BITS'(1),
                                     ent_block};
                    end
                    else if (ent_pins == '0)
                    begin
                        res_status_next = cbp_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = {ent_valid, ent_sc, ent_pins - PIN_BITS'(1), ent_block};
                    end
                end
                else if (!pend_reg && (idx_reg == n_reg))
                begin
                    // not resident
                    res_hit_next   = 1'b0;
                    res_idx_next   = '0;
                    res_fetch_next = 1'b0;
                    res_evv_next   = 1'b0;
                    res_evb_next   = '0;
                    if (cmd_reg == cbp_pkg::CMD_UNPIN)
                    begin
                        res_status_next = cbp_pkg::ST_NOT_RESIDENT;
                        state_next      = ST_OUT;
                    end
                    else
                    begin
                        mod_start  = 1'b1;
                        state_next = ST_MOD;
                    end
                end
                else if (idx_reg != n_reg)
                begin
                    mem_raddr      = idx_reg[HW-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg[HW-1:0];
                    idx_next       = idx_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    hand_next   = mod_rem;
                    sw_ptr_next = hand_step(mod_rem, n_reg);
                    pend_next   = 1'b0;
                    step_next   = '0;
                    state_next  = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                // read one frame ahead of the hand
                mem_raddr      = sw_ptr_reg;
                pend_next      = 1'b1;
                pend_addr_next = sw_ptr_reg;
                sw_ptr_next    = hand_step(sw_ptr_reg, n_reg);
                if (pend_reg)
                begin
                    hand_next = pend_addr_reg;
                    step_next = step_reg + (CNT_W+1)'(1);
                    if ((ent_pins == '0) && !ent_sc)
                    begin
                        // victim found: evict its block if valid and install
                        mem_we          = 1'b1;
                        mem_wdata       = {1'b1, 1'b1, PIN_BITS'(1), blk_reg};
                        res_hit_next    = 1'b0;
                        res_idx_next    = cbp_pkg::INDEX_W'(pend_addr_reg);
                        res_fetch_next  = 1'b1;
                        res_evv_next    = ent_valid;
                        res_evb_next    = ent_valid ? cbp_pkg::BLOCK_W'(ent_block) : '0;
                        res_status_next = cbp_pkg::ST_OK;
                        state_next      = ST_OUT;
                    end
                    else
                    begin
                        if (ent_pins == '0)
                        begin
                            // second chance used up
                            mem_we    = 1'b1;
                            mem_wdata = {ent_valid, 1'b0, ent_pins, ent_block};
                        end
                        if (sweep_end)
                        begin
                            res_status_next = cbp_pkg::ST_NO_FREE;
                            state_next      = ST_OUT;
                        end
                    end
                end
            end
            ST_OUT:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            idx_reg       <= '0;
            step_reg      <= '0;
            hand_reg      <= '0;
            fwd_hit_reg   <= 1'b0;
            fiu_reg       <= cbp_pkg::FIU_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            pend_reg    <= pend_next;
            idx_reg     <= idx_next;
            step_reg    <= step_next;
            hand_reg    <= hand_next;
            fwd_hit_reg <= mem_we && (mem_waddr == mem_raddr);
            if (cfg_wr_en)
            begin
                fiu_reg <= cfg_wr_data;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_next_latch: begin
            cmd_reg        <= cmd_next;
            blk_reg        <= blk_next;
            n_reg          <= n_next;
            sw_ptr_reg     <= sw_ptr_next;
            pend_addr_reg  <= pend_addr_next;
            fwd_data_reg   <= mem_wdata;
            res_hit_reg    <= res_hit_next;
            res_idx_reg    <= res_idx_next;
            res_fetch_reg  <= res_fetch_next;
            res_evv_reg    <= res_evv_next;
            res_evb_reg    <= res_evb_next;
            res_status_reg <= res_status_next;
        end
        if (rsp_load)
        begin
            rsp_hit_reg    <= res_hit_reg;
            rsp_idx_reg    <= res_idx_reg;
            rsp_fetch_reg  <= res_fetch_reg;
            rsp_evv_reg    <= res_evv_reg;
            rsp_evb_reg    <= res_evb_reg;
            rsp_status_reg <= res_status_reg;
        end
    end

    // result transfer
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.hit           = rsp_hit_reg;
    assign rsp.frame_index   = rsp_idx_reg;
    assign rsp.fetch_needed  = rsp_fetch_reg;
    assign rsp.evicted_valid = rsp_evv_reg;
    assign rsp.evicted_block = rsp_evb_reg;
    assign rsp.status        = rsp_status_reg;

endmodule

/* test/clock_buffer_pool_frame_manager_unit_tb.sv */
module clock_buffer_pool_frame_manager_unit_tb;

    localparam int FRAME_COUNT  = 64;
    localparam int PIN_BITS     = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2500;
    localparam int DRAIN_CYCLES = 250;
    localparam int RANDOM_ITEMS = 460;

    localparam logic [PIN_BITS-1:0] PIN_FULL = '1;

    typedef struct packed {
        logic                        hit;
        logic [cbp_pkg::INDEX_W-1:0] frame_index;
        logic                        fetch_needed;
        logic                        evicted_valid;
        logic [cbp_pkg::BLOCK_W-1:0] evicted_block;
        cbp_pkg::status_t            status;
    } frame_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [cbp_pkg::FIU_W-1:0] cfg_wr_data = '0;

    cbp_req_if req_bus ();
    cbp_rsp_if rsp_bus ();

    clock_buffer_pool_frame_manager_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_bus),
        .rsp         (rsp_bus),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // shadow copy of the frame table
    logic [cbp_pkg::BLOCK_W-1:0] pool_block [FRAME_COUNT];
    logic                        pool_valid [FRAME_COUNT];
    logic [PIN_BITS-1:0]         pool_pins  [FRAME_COUNT];
    logic                        pool_ref   [FRAME_COUNT];
    int                          pool_hand;
    logic [cbp_pkg::FIU_W-1:0]   pool_frames;

    frame_result_t expected_results [$];

    // run bookkeeping
    int mismatch_count  = 0;
    int requests_taken  = 0;
    int results_checked = 0;
    int hits_seen       = 0;
    int installs_seen   = 0;
    int evictions_seen  = 0;
    int no_free_seen    = 0;
    int unpin_errs_seen = 0;
    int stalled_cycles  = 0;

    // idling controls
    bit req_idle_on      = 1'b1;
    bit rsp_idle_on      = 1'b1;
    bit hold_off_request = 1'b0;
    int hold_off_left    = 0;
    int rsp_gap_left     = 0;

    // block ids reused within a random stretch
    logic [cbp_pkg::BLOCK_W-1:0] hot_blocks [16];
    int                          hot_count = 1;

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 4);
        return $urandom_range(12, 40);
    endfunction

    function automatic int active_frames();
        if (pool_frames == 0)
            return 1;
        if (pool_frames > FRAME_COUNT)
            return FRAME_COUNT;
        return int'(pool_frames);
    endfunction

    function automatic void clear_frame_table();
        int i;
        for (i = 0; i < FRAME_COUNT; i++)
        begin
            pool_block[i] = '0;
            pool_valid[i] = 1'b0;
            pool_pins[i]  = '0;
            pool_ref[i]   = 1'b0;
        end
        pool_hand   = 0;
        pool_frames = cbp_pkg::FIU_RESET;
    endfunction

    // lookup, second-chance sweep and pin bookkeeping for one request
    function automatic frame_result_t resolve_request(
        input logic cmd, input logic [cbp_pkg::BLOCK_W-1:0] blk);
        frame_result_t res;
        int n;
        int i;
        int found;
        int victim;
        int h;
        res   = '0;
        n     = active_frames();
        found = -1;
        for (i = 0; i < n; i++)
        begin
            if (found < 0 && pool_valid[i] && pool_block[i] == blk)
                found = i;
        end
        if (cmd == cbp_pkg::CMD_PIN)
        begin
            if (found >= 0)
            begin
                res.hit         = 1'b1;
                res.frame_index = cbp_pkg::INDEX_W'(found);
                if (pool_pins[found] != PIN_FULL)
                    pool_pins[found] = pool_pins[found] + PIN_BITS'(1);
                pool_ref[found] = 1'b1;
                hits_seen++;
            end
            else
            begin
                victim = -1;
                for (i = 0; i < 2 * n && victim < 0; i++)
                begin
                    h = (pool_hand + 1) % n;
                    pool_hand = h;
                    if (pool_pins[h] == '0)
                    begin
                        if (pool_ref[h])
                            pool_ref[h] = 1'b0;
                        else
                            victim = h;
                    end
                end
                if (victim < 0)
                begin
                    res.status = cbp_pkg::ST_NO_FREE;
                    no_free_seen++;
                end
                else
                begin
                    res.frame_index  = cbp_pkg::INDEX_W'(victim);
                    res.fetch_needed = 1'b1;
                    if (pool_valid[victim])
                    begin
                        res.evicted_valid = 1'b1;
                        res.evicted_block = pool_block[victim];
                        evictions_seen++;
                    end
                    pool_block[victim] = blk;
                    pool_valid[victim] = 1'b1;
                    pool_pins[victim]  = PIN_BITS'(1);
                    pool_ref[victim]   = 1'b1;
                    installs_seen++;
                end
            end
        end
        else
        begin
            if (found < 0)
            begin
                res.status = cbp_pkg::ST_NOT_RESIDENT;
                unpin_errs_seen++;
            end
            else
            begin
                res.hit         = 1'b1;
                res.frame_index = cbp_pkg::INDEX_W'(found);
                if (pool_pins[found] == '0)
                begin
                    res.status = cbp_pkg::ST_UNDERFLOW;
                    unpin_errs_seen++;
                end
                else
                    pool_pins[found] = pool_pins[found] - PIN_BITS'(1);
            end
        end
        return res;
    endfunction

    // predict on every request transfer
    always @(posedge clk)
    begin
        if (rst_n && req_bus.valid && req_bus.ready)
        begin
            expected_results.push_back(resolve_request(req_bus.command, req_bus.block_num));
            requests_taken++;
        end
    end

    task automatic report_field(input string field,
                                input logic [cbp_pkg::BLOCK_W-1:0] exp_val,
                                input logic [cbp_pkg::BLOCK_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            mismatch_count++;
            $error("%s: expected 0x%0h, got 0x%0h", field, exp_val, act_val);
        end
    endtask

    // compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        frame_result_t exp_res;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                $error("result transfer with no request outstanding");
            end
            else
            begin
                exp_res = expected_results.pop_front();
                report_field("hit", cbp_pkg::BLOCK_W'(exp_res.hit),
                             cbp_pkg::BLOCK_W'(rsp_bus.hit));
                report_field("frame_index", cbp_pkg::BLOCK_W'(exp_res.frame_index),
                             cbp_pkg::BLOCK_W'(rsp_bus.frame_index));
                report_field("fetch_needed", cbp_pkg::BLOCK_W'(exp_res.fetch_needed),
                             cbp_pkg::BLOCK_W'(rsp_bus.fetch_needed));
                report_field("evicted_valid", cbp_pkg::BLOCK_W'(exp_res.evicted_valid),
                             cbp_pkg::BLOCK_W'(rsp_bus.evicted_valid));
                report_field("evicted_block", exp_res.evicted_block, rsp_bus.evicted_block);
                report_field("status", cbp_pkg::BLOCK_W'(exp_res.status),
                             cbp_pkg::BLOCK_W'(rsp_bus.status));
                results_checked++;
            end
        end
    end

    // result side ready: random gaps plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_off_request)
        begin
            hold_off_request = 1'b0;
            hold_off_left    = HOLD_CYCLES;
        end
        if (!rst_n)
            rsp_bus.ready <= 1'b0;
        else if (hold_off_left > 0)
        begin
            rsp_bus.ready <= 1'b0;
            hold_off_left--;
        end
        else if (rsp_gap_left > 0)
        begin
            rsp_bus.ready <= 1'b0;
            rsp_gap_left--;
        end
        else
        begin
            rsp_bus.ready <= 1'b1;
            if (rsp_idle_on)
                rsp_gap_left = pick_gap();
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stalled_cycles <= 0;
        else if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    // offer one request and hold it until the transfer
    task automatic send_request(input logic cmd, input logic [cbp_pkg::BLOCK_W-1:0] blk);
        int gap;
        gap = req_idle_on ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.command   <= cmd;
        req_bus.block_num <= blk;
        do
            @(posedge clk);
        while (!req_bus.ready);
    endtask

    task automatic release_request();
        @(negedge clk);
        req_bus.valid <= 1'b0;
    endtask

    // register write once the block has drained
    task automatic set_frames_in_use(input logic [cbp_pkg::FIU_W-1:0] value);
        release_request();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        pool_frames = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic fill_hot_blocks(input int n);
        int i;
        hot_count = $urandom_range(2, (n + 3 > 16) ? 16 : n + 3);
        for (i = 0; i < hot_count; i++)
        begin
            case ($urandom_range(0, 9))
                0: hot_blocks[i] = '0;
                1: hot_blocks[i] = '1;
                default: hot_blocks[i] = $urandom;
            endcase
        end
    endtask

    // mostly pins of a small hot set and releases of resident blocks
    task automatic pick_request(output logic cmd, output logic [cbp_pkg::BLOCK_W-1:0] blk);
        int r;
        int f;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            cmd = cbp_pkg::CMD_PIN;
            blk = hot_blocks[$urandom_range(0, hot_count - 1)];
        end
        else if (r < 80)
        begin
            cmd = cbp_pkg::CMD_UNPIN;
            f   = $urandom_range(0, active_frames() - 1);
            blk = pool_valid[f] ? pool_block[f] : hot_blocks[$urandom_range(0, hot_count - 1)];
        end
        else if (r < 90)
        begin
            cmd = cbp_pkg::CMD_UNPIN;
            blk = hot_blocks[$urandom_range(0, hot_count - 1)];
        end
        else
        begin
            cmd = $urandom_range(0, 1) ? cbp_pkg::CMD_UNPIN : cbp_pkg::CMD_PIN;
            blk = $urandom;
        end
    endtask

    function automatic logic [cbp_pkg::FIU_W-1:0] pick_frames_setting();
        case ($urandom_range(0, 9))
            0: return 7'd0;
            1: return 7'd1;
            2: return 7'd127;
            3: return 7'd64;
            4: return 7'd2;
            5: return cbp_pkg::FIU_W'($urandom_range(3, 4));
            6: return cbp_pkg::FIU_W'($urandom_range(5, 16));
            7: return cbp_pkg::FIU_W'($urandom_range(17, 63));
            8: return cbp_pkg::FIU_W'($urandom_range(0, 127));
            default: return 7'd64;
        endcase
    endfunction

    // misses into empty frames, hits, releases and id extremes at reset count
    task automatic test_basic_pin_unpin();
        send_request(cbp_pkg::CMD_UNPIN, 32'h0000_0000);
        send_request(cbp_pkg::CMD_PIN,   32'h0000_0000);
        send_request(cbp_pkg::CMD_PIN,   32'h0000_0000);
        send_request(cbp_pkg::CMD_UNPIN, 32'h0000_0000);
        send_request(cbp_pkg::CMD_UNPIN, 32'h0000_0000);
        send_request(cbp_pkg::CMD_UNPIN, 32'h0000_0000);
        send_request(cbp_pkg::CMD_PIN,   32'hFFFF_FFFF);
        send_request(cbp_pkg::CMD_UNPIN, 32'hFFFF_FFFF);
        send_request(cbp_pkg::CMD_PIN,   32'hAAAA_AAAA);
        send_request(cbp_pkg::CMD_PIN,   32'h5555_5555);
    endtask

    // two frames, both pinned, then one released and reused
    task automatic test_pool_exhausted();
        set_frames_in_use(7'd2);
        send_request(cbp_pkg::CMD_PIN,   32'h0000_0100);
        send_request(cbp_pkg::CMD_PIN,   32'h0000_0101);
        send_request(cbp_pkg::CMD_PIN,   32'h0000_0102);
        send_request(cbp_pkg::CMD_UNPIN, 32'h0000_0100);
        send_request(cbp_pkg::CMD_PIN,   32'h0000_0102);
        send_request(cbp_pkg::CMD_UNPIN, 32'h0000_0077);
    endtask

    // zero acts as one frame, oversize acts as the full pool
    task automatic test_count_extremes();
        set_frames_in_use(7'd0);
        send_request(cbp_pkg::CMD_UNPIN, 32'h0000_0101);
        send_request(cbp_pkg::CMD_UNPIN, 32'h0000_0100);
        send_request(cbp_pkg::CMD_PIN,   32'h5555_5555);
        set_frames_in_use(7'd127);
        send_request(cbp_pkg::CMD_PIN,   32'h5555_5555);
        send_request(cbp_pkg::CMD_UNPIN, 32'h5555_5555);
        send_request(cbp_pkg::CMD_PIN,   32'hAAAA_AAAA);
        set_frames_in_use(7'd64);
    endtask

    // result side holds off while requests keep coming
    task automatic test_input_backpressure();
        int i;
        req_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        @(posedge clk);
        hold_off_request = 1'b1;
        for (i = 0; i < 16; i++)
            send_request((i % 3 == 2) ? cbp_pkg::CMD_UNPIN : cbp_pkg::CMD_PIN,
                         32'h0C00_0000 + (i % 4));
        release_request();
        req_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
    endtask

    // stretches of random traffic, each with its own frame count and idling
    task automatic test_random_traffic();
        int sent;
        int stretch;
        logic cmd;
        logic [cbp_pkg::BLOCK_W-1:0] blk;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            set_frames_in_use(pick_frames_setting());
            fill_hot_blocks(active_frames());
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
            stretch = $urandom_range(30, 70);
            repeat (stretch)
            begin
                pick_request(cmd, blk);
                send_request(cmd, blk);
                sent++;
            end
        end
        release_request();
        req_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
    endtask

    // one frame: release what it holds, pin one block a few times, release past zero
    task automatic test_single_frame();
        logic [cbp_pkg::BLOCK_W-1:0] busy_blk;
        set_frames_in_use(7'd1);
        req_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        while (pool_valid[0] && pool_pins[0] != '0)
        begin
            busy_blk = pool_block[0];
            send_request(cbp_pkg::CMD_UNPIN, busy_blk);
        end
        repeat (6)
            send_request(cbp_pkg::CMD_PIN, 32'hC3A5_0F96);
        send_request(cbp_pkg::CMD_PIN, 32'h0000_0042);
        repeat (8)
            send_request(cbp_pkg::CMD_UNPIN, 32'hC3A5_0F96);
        send_request(cbp_pkg::CMD_PIN, 32'h0000_0042);
        release_request();
        req_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
    endtask

    initial
    begin
        req_bus.valid     = 1'b0;
        req_bus.command   = cbp_pkg::CMD_PIN;
        req_bus.block_num = '0;
        clear_frame_table();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_pin_unpin();
        test_pool_exhausted();
        test_count_extremes();
        test_input_backpressure();
        test_random_traffic();
        test_single_frame();

        release_request();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d requests and %0d checked results: %0d hits, %0d installs",
                 requests_taken, results_checked, hits_seen, installs_seen);
        $display("%0d evictions, %0d pool-full misses, %0d rejected releases, %0d mismatches",
                 evictions_seen, no_free_seen, unpin_errs_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* clock_buffer_pool_frame_manager_unit.f */
hdl/cbp_pkg.sv
hdl/cbp_req_if.sv
hdl/cbp_rsp_if.sv
hdl/cbp_frame_mem.sv
hdl/cbp_hand_mod.sv
hdl/clock_buffer_pool_frame_manager_unit.sv
test/clock_buffer_pool_frame_manager_unit_tb.sv
